// File: design/mat_pkg.sv
// Shared types, constants and codes for the multi-slot alarm timer.
package mat_pkg;

    localparam int SLOTS       = 4;
    localparam int TIME_BITS   = 32;
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_BITS   = 4;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_SET  = 2'd1,
        ACT_DEL  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_TICK_NONE = 3'd1,
        KIND_SET_OK    = 3'd2,
        KIND_SET_FULL  = 3'd3,
        KIND_DEL_OK    = 3'd4,
        KIND_DEL_BAD   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  busy;
        time_t expiry;
        time_t reload;
    } slot_rec_t;

    // what the head cell reports for the slot passing through it
    typedef struct packed {
        logic fire;
        logic keep;
        logic claim;
    } head_stat_t;

    localparam slot_rec_t FREE_REC = '{busy: 1'b0, expiry: '1, reload: '0};

endpackage

// File: design/mat_cell.sv
// One slot cell of the rotating chain; passes its record on while shifting.
module mat_cell
    import mat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  slot_rec_t rec_in,
    output slot_rec_t rec_out
);

    slot_rec_t rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= FREE_REC;
        end
        else if (shift)
        begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

// File: design/mat_head.sv
// Update of the slot record leaving the head of the chain: fire, claim or free.
module mat_head
    import mat_pkg::*;
(
    input  action_t          op,
    input  slot_rec_t        rec_in,
    input  time_t            now,
    input  time_t            delay,
    input  time_t            rep,
    input  logic [SLOT_BITS-1:0] del_idx,
    input  logic [SLOT_BITS-1:0] slot_no,
    input  logic             found,
    output slot_rec_t        rec_out,
    output head_stat_t       stat
);

    time_t addend;
    time_t sum;
    logic  due;

    // one adder: reload for a refire, delay for a claim
    assign addend = (op == ACT_TICK) ? rec_in.reload : delay;
    assign sum    = now + addend;
    assign due    = rec_in.busy && (rec_in.expiry <= now);

    always_comb
    begin
        rec_out = rec_in;
        stat    = '0;
        case (op)
            ACT_TICK:
            begin
                stat.fire = due;
                if (due)
                begin
                    if (rec_in.reload != '0)
                    begin
                        rec_out.expiry = sum;
                        stat.keep      = 1'b1;
                    end
                    else
                    begin
                        rec_out = FREE_REC;
                    end
                end
                else
                begin
                    stat.keep = rec_in.busy;
                end
            end
            ACT_SET:
            begin
                if (!rec_in.busy && !found)
                begin
                    stat.claim = 1'b1;
                    rec_out    = '{busy: 1'b1, expiry: sum, reload: rep};
                end
            end
            ACT_DEL:
            begin
                if (slot_no == del_idx)
                begin
                    rec_out = FREE_REC;
                end
            end
            default:
            begin
                rec_out = rec_in;
            end
        endcase
    end

endmodule

// File: design/multi_slot_alarm_timer.sv
// Top level of the multi-slot alarm timer: slot chain, sequencer, output register.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tuser action, tdata delay/repeat/slot_index
//  m_axis   out  m_axis_tvalid/m_axis_tready    tuser kind, tdata slot/alarm_enable, tlast
//
//  Every word runs one full turn of the slot chain, one slot passing the
//  head cell per cycle, where a single adder and comparator act on it.
//  Then results leave one per cycle while the output is not stalled; a word
//  has 1 result, or on a tick the slots fired, at most MAX_RESULTS.
//  Action 3 words are taken and dropped.
//  A stalled output holds its result; the next word is taken once the last
//  result of the current one sits in the output register.
//  Reset frees all slots, clears the time and the pending flag at once.
module multi_slot_alarm_timer
    import mat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // delay[31:0], repeat_interval[63:32], slot_index[67:64]
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // slot[3:0], alarm_enable[4]
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    // sequencer and item registers
    state_t               state_reg,  state_next;
    logic [IDX_W-1:0]     cnt_reg,    cnt_next;
    time_t                time_reg,   time_next;
    logic                 pend_reg,   pend_next;
    logic                 any_reg,    any_next;
    logic                 found_reg,  found_next;
    logic [SLOT_BITS-1:0] fslot_reg,  fslot_next;
    logic [SLOTS-1:0]     fired_reg,  fired_next;
    logic [RCNT_W-1:0]    rcnt_reg,   rcnt_next;
    action_t              op_reg,     op_next;
    time_t                delay_reg,  delay_next;
    time_t                rep_reg,    rep_next;
    logic [SLOT_BITS-1:0] idx_reg,    idx_next;

    // output register
    logic                 mvalid_reg, mvalid_next;
    kind_t                mkind_reg,  mkind_next;
    logic [SLOT_BITS-1:0] mslot_reg,  mslot_next;
    logic                 men_reg,    men_next;
    logic                 mlast_reg,  mlast_next;

    logic                 in_take;
    logic                 out_free;
    logic                 shift;
    slot_rec_t            cell_rec [SLOTS];
    slot_rec_t            head_out;
    head_stat_t           head_stat;
    logic [SLOT_BITS-1:0] head_slot;
    logic [IDX_W-1:0]     pick;
    logic [SLOTS-1:0]     fired_rest;
    action_t              in_op;

    assign in_op     = action_t'(s_axis_tuser);
    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !mvalid_reg || m_axis_tready;
    assign shift     = (state_reg == ST_SCAN);
    assign head_slot = SLOT_BITS'(cnt_reg);

    // slot chain: cell 0 is the head, its updated record re-enters at the tail
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        mat_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .rec_in  ((i == SLOTS - 1) ? head_out : cell_rec[(i + 1) % SLOTS]),
            .rec_out (cell_rec[i])
        );
    end

    mat_head u_head (
        .op      (op_reg),
        .rec_in  (cell_rec[0]),
        .now     (time_reg),
        .delay   (delay_reg),
        .rep     (rep_reg),
        .del_idx (idx_reg),
        .slot_no (head_slot),
        .found   (found_reg),
        .rec_out (head_out),
        .stat    (head_stat)
    );

    // lowest fired slot still to report
    always_comb
    begin
        pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (fired_reg[i])
            begin
                pick = IDX_W'(i);
            end
        end
    end

    assign fired_rest = fired_reg & ~(SLOTS'(1) << pick);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        time_next   = time_reg;
        pend_next   = pend_reg;
        any_next    = any_reg;
        found_next  = found_reg;
        fslot_next  = fslot_reg;
        fired_next  = fired_reg;
        rcnt_next   = rcnt_reg;
        op_next     = op_reg;
        delay_next  = delay_reg;
        rep_next    = rep_reg;
        idx_next    = idx_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        mkind_next  = mkind_reg;
        mslot_next  = mslot_reg;
        men_next    = men_reg;
        mlast_next  = mlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (in_op != ACT_NONE))
                begin
                    op_next    = in_op;
                    delay_next = TIME_BITS'(s_axis_tdata[31:0]);
                    rep_next   = TIME_BITS'(s_axis_tdata[63:32]);
                    idx_next   = s_axis_tdata[67:64];
                    cnt_next   = '0;
                    any_next   = 1'b0;
                    found_next = 1'b0;
                    fslot_next = '0;
                    fired_next = '0;
                    rcnt_next  = '0;
                    if (in_op == ACT_TICK)
                    begin
                        time_next = time_reg + TIME_BITS'(1);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (head_stat.fire)
                begin
                    fired_next[cnt_reg] = 1'b1;
                end
                if (head_stat.keep)
                begin
                    any_next = 1'b1;
                end
                if (head_stat.claim)
                begin
                    found_next = 1'b1;
                    fslot_next = head_slot;
                end
                if (cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    cnt_next = '0;
                    if (op_reg == ACT_TICK)
                    begin
                        pend_next = any_next;
                    end
                    else if ((op_reg == ACT_SET) && found_next)
                    begin
                        pend_next = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    men_next    = pend_reg;
                    mlast_next  = 1'b1;
                    mslot_next  = '0;
                    state_next  = ST_IDLE;
                    case (op_reg)
                        ACT_TICK:
                        begin
                            if (fired_reg == '0)
                            begin
                                mkind_next = KIND_TICK_NONE;
                            end
                            else
                            begin
                                mkind_next = KIND_FIRED;
                                mslot_next = SLOT_BITS'(pick);
                                fired_next = fired_rest;
                                rcnt_next  = rcnt_reg + RCNT_W'(1);
                                if ((fired_rest != '0) &&
                                    (rcnt_reg != RCNT_W'(MAX_RESULTS - 1)))
                                begin
                                    mlast_next = 1'b0;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        ACT_SET:
                        begin
                            mkind_next = found_reg ? KIND_SET_OK : KIND_SET_FULL;
                            mslot_next = fslot_reg;
                        end
                        default:
                        begin
                            mkind_next = ({1'b0, idx_reg} < (SLOT_BITS + 1)'(SLOTS)) ?
                                         KIND_DEL_OK : KIND_DEL_BAD;
                            mslot_next = idx_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            time_reg   <= '0;
            pend_reg   <= 1'b0;
            any_reg    <= 1'b0;
            found_reg  <= 1'b0;
            fired_reg  <= '0;
            rcnt_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            time_reg   <= time_next;
            pend_reg   <= pend_next;
            any_reg    <= any_next;
            found_reg  <= found_next;
            fired_reg  <= fired_next;
            rcnt_reg   <= rcnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        fslot_reg <= fslot_next;
        op_reg    <= op_next;
        delay_reg <= delay_next;
        rep_reg   <= rep_next;
        idx_reg   <= idx_next;
        mkind_reg <= mkind_next;
        mslot_reg <= mslot_next;
        men_reg   <= men_next;
        mlast_reg <= mlast_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tuser  = mkind_reg;
    assign m_axis_tdata  = {3'b000, men_reg, mslot_reg};
    assign m_axis_tlast  = mlast_reg;

    // chain position counter only moves during a turn
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (cnt_reg == '0))
        else $error("slot counter off zero outside scan");

    // a tick never reports more results than allowed
    a_rcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rcnt_reg < RCNT_W'(MAX_RESULTS)))
        else $error("too many fired results");

    // a claimed slot always leaves the timer pending
    a_set_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && (mkind_reg == KIND_SET_OK)) |-> men_reg)
        else $error("set ok without alarm enable");

endmodule
